/* src/ps2mt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_W          = 13;   // widest configuration register
  localparam int CFG_IDX_W      = 2;
  localparam int BYTE_W         = 8;
  localparam int BTN_W          = 3;
  localparam int DELTA_W        = 9;    // negated -128 needs a ninth bit
  localparam int SYNC_BIT       = 3;    // always set in a packet's first byte

  localparam int SCREEN_W_RST   = 1024;
  localparam int SCREEN_H_RST   = 768;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 2'd2;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_DX   = 2'd1,
    PH_DY   = 2'd2
  } phase_t;

endpackage

/* src/ps2mt_byte_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_byte_if
// Valid/ready channel carrying one received mouse byte.
// ----------------------------------------------------------------------------
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/ps2mt_pkt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_pkt_if
// Valid/ready channel carrying one decoded packet: position and buttons.
// ----------------------------------------------------------------------------
interface ps2mt_pkt_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_position;
  logic [COORD_BITS-1:0] y_position;
  logic [2:0]            button_bits;
  logic                  left_pressed;
  logic                  left_released;
  logic                  right_pressed;
  logic                  middle_pressed;
  logic                  moved;

  modport source (
    output valid, output x_position, output y_position, output button_bits,
    output left_pressed, output left_released, output right_pressed,
    output middle_pressed, output moved, input ready
  );
  modport sink (
    input valid, input x_position, input y_position, input button_bits,
    input left_pressed, input left_released, input right_pressed,
    input middle_pressed, input moved, output ready
  );
endinterface

/* src/ps2mt_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mt_axis
// One cursor axis: screen limit from the size register, step and clamp.
// ----------------------------------------------------------------------------
module ps2mt_axis #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic [ps2mt_pkg::CFG_W-1:0]          size_reg,
  input  logic [COORD_BITS-1:0]                cursor,
  input  logic signed [ps2mt_pkg::DELTA_W-1:0] delta,
  output logic [COORD_BITS-1:0]                position_next,
  output logic [COORD_BITS-1:0]                center
);
  import ps2mt_pkg::*;

  localparam int LIM_W = COORD_BITS + 1;
  localparam int RW    = (CFG_W > LIM_W) ? CFG_W : LIM_W;
  localparam int SUM_W = COORD_BITS + 2;

  logic [RW-1:0]           size_ext;
  logic [RW-1:0]           cap;
  logic [LIM_W-1:0]        limit;
  logic [LIM_W-1:0]        limit_m1;
  logic signed [SUM_W-1:0] sum;

  assign size_ext = RW'(size_reg);
  assign cap      = RW'(1) << COORD_BITS;

  // zero size acts as one pixel, oversize is capped at the coordinate range
  always_comb begin
    if (size_ext == '0) begin
      limit = LIM_W'(1);
    end else if (size_ext > cap) begin
      limit = LIM_W'(cap);
    end else begin
      limit = LIM_W'(size_ext);
    end
  end

  assign limit_m1 = limit - LIM_W'(1);
  assign center   = limit[LIM_W-1:1];
  assign sum      = $signed({2'b00, cursor}) + SUM_W'(delta);

  always_comb begin
    if (sum < 0) begin
      position_next = '0;
    end else if ($unsigned(sum) >= {1'b0, limit}) begin
      position_next = limit_m1[COORD_BITS-1:0];
    end else begin
      position_next = sum[COORD_BITS-1:0];
    end
  end

endmodule

/* src/ps2_mouse_packet_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_core
// Assembles PS/2 mouse bytes into three-byte packets and tracks the cursor.
// ----------------------------------------------------------------------------
// A packet result is loaded into the output register at the edge that
// takes its third byte. Throughput: one byte per cycle while
// results are taken; a result waiting in the output register holds off every
// byte until it is taken, and a byte can enter in the cycle the result leaves.
// Reset (rst, synchronous): disabled, size 1024x768, cursor centered,
// packet phase and buttons cleared, output empty.
module ps2_mouse_packet_tracker_core #(
  parameter int COORD_BITS = ps2mt_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mt_pkg::CFG_W-1:0]     cfg_data,
  ps2mt_byte_if.sink                      byte_in,
  ps2mt_pkt_if.source                     pkt_out
);
  import ps2mt_pkg::*;

  localparam int CAP       = 1 << COORD_BITS;
  localparam int RST_LIM_X = (SCREEN_W_RST > CAP) ? CAP : SCREEN_W_RST;
  localparam int RST_LIM_Y = (SCREEN_H_RST > CAP) ? CAP : SCREEN_H_RST;
  localparam logic [COORD_BITS-1:0] RST_CX = COORD_BITS'(RST_LIM_X / 2);
  localparam logic [COORD_BITS-1:0] RST_CY = COORD_BITS'(RST_LIM_Y / 2);

  logic                  enabled;
  logic [CFG_W-1:0]      size_x;
  logic [CFG_W-1:0]      size_y;
  phase_t                phase;
  phase_t                phase_next;
  logic [BTN_W-1:0]      flag_buttons;
  logic [BYTE_W-1:0]     dx_byte;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [BTN_W-1:0]      held_buttons;

  logic                  accept;
  logic                  live;
  logic                  capture_flag;
  logic                  capture_dx;
  logic                  pkt_done;
  logic                  recenter;
  logic [BYTE_W-1:0]     b;

  logic signed [DELTA_W-1:0] dx_delta;
  logic signed [DELTA_W-1:0] dy_raw;
  logic signed [DELTA_W-1:0] dy_delta;
  logic [COORD_BITS-1:0] x_next;
  logic [COORD_BITS-1:0] y_next;
  logic [COORD_BITS-1:0] x_center;
  logic [COORD_BITS-1:0] y_center;

  logic out_valid;

  assign b              = byte_in.rx_byte;
  assign byte_in.ready  = !out_valid || pkt_out.ready;
  assign accept         = byte_in.valid && byte_in.ready;
  assign live           = accept && enabled;

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (live) begin
      case (phase)
        PH_DX:   phase_next = PH_DY;
        PH_DY:   phase_next = PH_FLAG;
        default: phase_next = b[SYNC_BIT] ? PH_DX : PH_FLAG;
      endcase
    end
  end

  always_comb begin
    capture_flag = 1'b0;
    capture_dx   = 1'b0;
    pkt_done     = 1'b0;
    if (live) begin
      case (phase)
        PH_DX:   capture_dx   = 1'b1;
        PH_DY:   pkt_done     = 1'b1;
        default: capture_flag = b[SYNC_BIT];
      endcase
    end
  end

  assign dx_delta = $signed({dx_byte[BYTE_W-1], dx_byte});
  assign dy_raw   = $signed({b[BYTE_W-1], b});
  assign dy_delta = -dy_raw;   // screen y grows downward

  ps2mt_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .size_reg      (size_x),
    .cursor        (cursor_x),
    .delta         (dx_delta),
    .position_next (x_next),
    .center        (x_center)
  );

  ps2mt_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .size_reg      (size_y),
    .cursor        (cursor_y),
    .delta         (dy_delta),
    .position_next (y_next),
    .center        (y_center)
  );

  assign recenter = cfg_we && (cfg_index == CFG_ENABLED) && cfg_data[0] && !enabled;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      size_x  <= CFG_W'(SCREEN_W_RST);
      size_y  <= CFG_W'(SCREEN_H_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:  enabled <= cfg_data[0];
        CFG_SCREEN_W: size_x  <= cfg_data;
        CFG_SCREEN_H: size_y  <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FLAG;
      flag_buttons <= '0;
      dx_byte      <= '0;
      cursor_x     <= RST_CX;
      cursor_y     <= RST_CY;
      held_buttons <= '0;
    end else begin
      phase <= phase_next;
      if (capture_flag) begin
        flag_buttons <= b[BTN_W-1:0];
      end
      if (capture_dx) begin
        dx_byte <= b;
      end
      if (recenter) begin
        cursor_x <= x_center;
        cursor_y <= y_center;
      end else if (pkt_done) begin
        cursor_x     <= x_next;
        cursor_y     <= y_next;
        held_buttons <= flag_buttons;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pkt_done) begin
      out_valid <= 1'b1;
    end else if (pkt_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      pkt_out.x_position     <= x_next;
      pkt_out.y_position     <= y_next;
      pkt_out.button_bits    <= flag_buttons;
      pkt_out.left_pressed   <= flag_buttons[0] && !held_buttons[0];
      pkt_out.left_released  <= !flag_buttons[0] && held_buttons[0];
      pkt_out.right_pressed  <= flag_buttons[1] && !held_buttons[1];
      pkt_out.middle_pressed <= flag_buttons[2] && !held_buttons[2];
      pkt_out.moved          <= (dx_byte != '0) || (b != '0);
    end
  end

  assign pkt_out.valid = out_valid;

endmodule
